// ===== rtl/ship_pkg.sv =====
package ship_pkg;

  // Field widths of one request word
  localparam int unsigned CORE_W   = 3;
  localparam int unsigned SETIDX_W = 11;
  localparam int unsigned WAYIN_W  = 4;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned VICT_W   = 4;

  // Per-line state: {rrpv, signature}
  localparam int unsigned RRPV_W = 2;
  localparam int unsigned SIG_W  = 4;
  localparam int unsigned LANE_W = RRPV_W + SIG_W;
  localparam int unsigned NSIG   = 16;

  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd1;
  localparam logic [RRPV_W-1:0] RRPV_HIT  = 2'd0;
  localparam logic [LANE_W-1:0] LANE_INIT = {RRPV_MAX, 4'd0};

  // Reuse counters
  localparam int unsigned        CTR_W      = 2;
  localparam logic [CTR_W-1:0]   CTR_INIT   = 2'd2;
  localparam logic [CTR_W-1:0]   CTR_MAX    = 2'd3;
  localparam logic [CTR_W-1:0]   CTR_THRESH = 2'd2;

  // Commands
  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Default geometry
  localparam int unsigned SETS_DEF  = 2048;
  localparam int unsigned WAYS_DEF  = 16;
  localparam int unsigned CORES_DEF = 1;

  // Shift of the reciprocal used to fold the set index into range
  localparam int unsigned RECIP_SH = 2 * SETIDX_W;

  typedef struct packed {
    logic              en;
    logic [SIG_W-1:0]  idx;
    logic [CTR_W-1:0]  val;
  } ctr_wr_t;

  function automatic logic [SIG_W-1:0] sig_of(input logic [ADDR_W-1:0] pc);
    sig_of = pc[5:2] ^ pc[10:7];
  endfunction

endpackage

// ===== rtl/ship_rrip_replacement.sv =====
// Replacement engine for a set-associative cache: per-line 2-bit re-reference
// value plus 4-bit PC signature, a 16-entry table of 2-bit reuse counters and
// a per-core stride detector. Each set's line state sits in one word of a
// single-port-per-side synchronous RAM (WAYS x 6 bits, SETS deep) that is
// read, modified and written back. After reset the block sweeps the RAM, one
// set a cycle, holding in_ready_o low. Afterwards it works on one word at a
// time: a victim command folds the set index, reads the RAM, then ages and
// picks, holding before write-back while the output register is full; an
// update folds and reads the same way, writes back on a hit, ends without a
// write when the way is out of range, and on a miss fill adds a state for the
// second reuse-counter access. A finished victim waits in an output register,
// so a new word is accepted while it is still unclaimed.
module ship_rrip_replacement
  import ship_pkg::*;
#(
  parameter int unsigned SETS  = SETS_DEF,
  parameter int unsigned WAYS  = WAYS_DEF,
  parameter int unsigned CORES = CORES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [CORE_W-1:0]   core_i,
  input  logic [SETIDX_W-1:0] set_index_i,
  input  logic [WAYIN_W-1:0]  way_i,
  input  logic [ADDR_W-1:0]   pc_i,
  input  logic [ADDR_W-1:0]   paddr_i,
  input  logic                hit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VICT_W-1:0]   victim_way_o
);

  localparam int unsigned SAW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW     = $clog2(WAYS);
  localparam int unsigned WORD_W = WAYS * LANE_W;
  localparam int unsigned PROD_W = SETIDX_W + RECIP_SH + 1;

  // Reciprocal of SETS; exact floor quotient for every 11-bit index
  localparam logic [RECIP_SH:0] RECIP = (RECIP_SH + 1)'((1 << RECIP_SH) / SETS + 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [SAW-1:0]      clr_q, clr_d;

  // Captured request word
  logic                cmd_q;
  logic [CORE_W-1:0]   core_q;
  logic [SETIDX_W-1:0] set_q;
  logic [SETIDX_W-1:0] quot_q;
  logic [WAYIN_W-1:0]  way_q;
  logic [SIG_W-1:0]    sig_q;
  logic [ADDR_W-1:0]   paddr_q;
  logic                hit_q;
  logic [SAW-1:0]      addr_q;
  logic                stream_q;

  logic                out_valid_q, out_valid_d;
  logic [VICT_W-1:0]   victim_q, victim_d;

  logic                accept;
  logic [PROD_W-1:0]   prod;
  logic [SETIDX_W-1:0] qmul;
  logic [SETIDX_W-1:0] rem;
  logic [SAW-1:0]      set_addr;

  logic                mem_we;
  logic [SAW-1:0]      mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [WORD_W-1:0]   mem_rdata;

  logic                streaming;
  logic [SIG_W-1:0]    ctr_raddr;
  logic [CTR_W-1:0]    ctr_rdata;
  ctr_wr_t             ctr_wr;

  logic                slot_free;
  logic                way_ok;
  logic [WW-1:0]       lane_idx;
  logic [LANE_W-1:0]   old_lane;
  logic [RRPV_W-1:0]   old_rrpv;
  logic [SIG_W-1:0]    old_sig;
  logic [RRPV_W-1:0]   ins_rrpv;
  logic [LANE_W-1:0]   new_lane;
  logic [WORD_W-1:0]   upd_word;

  logic [RRPV_W-1:0]   rv   [WAYS];
  logic [WAYS-1:0]     is3;
  logic [WAYS-1:0]     hi_bit;
  logic [WAYS-1:0]     lo_bit;
  logic [RRPV_W-1:0]   top;
  logic [RRPV_W-1:0]   age;
  logic [WORD_W-1:0]   aged_word;
  logic [WAYS-1:0]     aged3;
  logic [WW-1:0]       vic;

  assign in_ready_o   = (state_q == S_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;
  assign slot_free    = !out_valid_q || out_ready_i;

  // Fold the set index into range: quotient by reciprocal now, remainder next cycle
  assign prod     = set_index_i * RECIP;
  assign qmul     = SETIDX_W'(quot_q * SETS);
  assign rem      = set_q - qmul;
  assign set_addr = SAW'(rem);

  ship_set_ram #(
    .DEPTH (SETS),
    .WIDTH (WORD_W),
    .AW    (SAW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (set_addr),
    .rdata_o (mem_rdata)
  );

  ship_stride #(
    .CORES (CORES)
  ) u_stride (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        ((state_q == S_ADDR) && (cmd_q == CMD_UPDATE)),
    .core_i      (core_q),
    .paddr_i     (paddr_q),
    .streaming_o (streaming)
  );

  ship_ctr_table u_ctr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (ctr_raddr),
    .rdata_o (ctr_rdata),
    .wr_i    (ctr_wr)
  );

  assign mem_re = (state_q == S_ADDR);

  // Victim path: age every way by the same amount until one reaches the maximum
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rv[w]     = mem_rdata[w*LANE_W + SIG_W +: RRPV_W];
      is3[w]    = (rv[w] == RRPV_MAX);
      hi_bit[w] = rv[w][1];
      lo_bit[w] = rv[w][0];
    end
    if (|is3) begin
      top = RRPV_MAX;
    end else if (|hi_bit) begin
      top = 2'd2;
    end else if (|lo_bit) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    age       = RRPV_MAX - top;
    aged_word = mem_rdata;
    for (int w = 0; w < WAYS; w++) begin
      aged_word[w*LANE_W + SIG_W +: RRPV_W] = rv[w] + age;
      aged3[w] = ((rv[w] + age) == RRPV_MAX);
    end
    vic = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (aged3[w]) begin
        vic = WW'(w);
      end
    end
  end

  // Update path: one lane of the set word
  assign way_ok   = int'(way_q) < WAYS;
  assign lane_idx = WW'(way_q);
  assign old_lane = mem_rdata[lane_idx*LANE_W +: LANE_W];
  assign old_rrpv = old_lane[LANE_W-1 -: RRPV_W];
  assign old_sig  = old_lane[SIG_W-1:0];

  assign ins_rrpv = (stream_q || (ctr_rdata < CTR_THRESH)) ? RRPV_MAX : RRPV_NEAR;

  always_comb begin
    if (state_q == S_INS) begin
      new_lane = {ins_rrpv, sig_q};
    end else begin
      new_lane = {RRPV_HIT, old_sig};
    end
    upd_word = mem_rdata;
    upd_word[lane_idx*LANE_W +: LANE_W] = new_lane;
  end

  // Counter table: evicted/hit signature first, then the incoming one
  assign ctr_raddr = (state_q == S_INS) ? sig_q : old_sig;

  always_comb begin
    ctr_wr.en  = 1'b0;
    ctr_wr.idx = old_sig;
    ctr_wr.val = ctr_rdata;
    if ((state_q == S_MOD) && (cmd_q == CMD_UPDATE) && way_ok) begin
      if (hit_q) begin
        ctr_wr.en  = (ctr_rdata != CTR_MAX);
        ctr_wr.val = ctr_rdata + 2'd1;
      end else begin
        ctr_wr.en  = (old_rrpv != RRPV_HIT) && (ctr_rdata != '0);
        ctr_wr.val = ctr_rdata - 2'd1;
      end
    end
  end

  // Sequencer and write-back selection
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = upd_word;
    out_valid_d = out_valid_q && !out_ready_i;
    victim_d    = victim_q;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {WAYS{LANE_INIT}};
        clr_d     = clr_q + 1'b1;
        if (clr_q == SAW'(SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        state_d = S_MOD;
      end
      S_MOD: begin
        if (cmd_q == CMD_VICTIM) begin
          // hold until the output register can take the word
          if (slot_free) begin
            mem_we      = 1'b1;
            mem_wdata   = aged_word;
            out_valid_d = 1'b1;
            victim_d    = VICT_W'(vic);
            state_d     = S_IDLE;
          end
        end else if (!way_ok) begin
          state_d = S_IDLE;
        end else if (hit_q) begin
          mem_we  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        mem_we  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    victim_q <= victim_d;
    if (accept) begin
      cmd_q   <= cmd_i;
      core_q  <= core_i;
      set_q   <= set_index_i;
      quot_q  <= prod[RECIP_SH +: SETIDX_W];
      way_q   <= way_i;
      sig_q   <= sig_of(pc_i);
      paddr_q <= paddr_i;
      hit_q   <= hit_i;
    end
    if (state_q == S_ADDR) begin
      addr_q   <= set_addr;
      stream_q <= streaming;
    end
  end

endmodule

// ===== rtl/ship_set_ram.sv =====
module ship_set_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ship_ctr_table.sv =====
module ship_ctr_table
  import ship_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SIG_W-1:0] raddr_i,
  output logic [CTR_W-1:0] rdata_o,
  input  ctr_wr_t          wr_i
);

  logic [CTR_W-1:0] ctr_q [NSIG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSIG; i++) begin
        ctr_q[i] <= CTR_INIT;
      end
    end else if (wr_i.en) begin
      ctr_q[wr_i.idx] <= wr_i.val;
    end
  end

  assign rdata_o = ctr_q[raddr_i];

endmodule

// ===== rtl/ship_stride.sv =====
module ship_stride
  import ship_pkg::*;
#(
  parameter int unsigned CORES = CORES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CORE_W-1:0] core_i,
  input  logic [ADDR_W-1:0] paddr_i,
  output logic              streaming_o
);

  localparam int unsigned CW = (CORES > 1) ? $clog2(CORES) : 1;

  logic [ADDR_W-1:0] prev_addr_q  [CORES];
  logic [ADDR_W-1:0] prev_delta_q [CORES];

  logic              core_ok;
  logic [CW-1:0]     cidx;
  logic [ADDR_W-1:0] prev_addr;
  logic [ADDR_W-1:0] delta;

  assign core_ok   = int'(core_i) < CORES;
  assign cidx      = CW'(core_i);
  assign prev_addr = prev_addr_q[cidx];

  // First access after reset sees no stride
  assign delta = (prev_addr == '0) ? '0 : paddr_i - prev_addr;

  assign streaming_o = core_ok && (delta != '0) && (delta == prev_delta_q[cidx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CORES; i++) begin
        prev_addr_q[i]  <= '0;
        prev_delta_q[i] <= '0;
      end
    end else if (en_i && core_ok) begin
      prev_addr_q[cidx]  <= paddr_i;
      prev_delta_q[cidx] <= delta;
    end
  end

endmodule
